// ===== hdl/positional_list_engine_core_defines.svh =====
// Assertion macros shared by the list engine RTL.
// No dependencies; included by the top level only.
`ifndef POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define PLE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("list engine check failed");

// Next-cycle implication, checked only out of reset.
`define PLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("list engine check failed");

`endif

// ===== hdl/ple_pkg.sv =====
// Shared codes and types for the positional list engine.
// No dependencies; used by ple_cell and positional_list_engine_core.
package ple_pkg;

    localparam int WORD_W = 32;

    // opcode field
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // status field
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // what every cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_READ = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [WORD_W-1:0]  value;
    } t_cell_ctl;

endpackage

// ===== hdl/positional_list_engine_core.sv =====
// Top level of the positional list engine: control, result register, cell row.
// Depends on ple_pkg, ple_cell and positional_list_engine_core_defines.svh.
//
//  channel   | direction | handshake                | beat fields
//  ----------+-----------+--------------------------+----------------------------------
//  command   | in        | start high, busy low     | i_opcode, i_value, i_position
//  result    | out       | o_valid, one cycle       | o_status, o_read_value,
//            |           |                          | o_entry_count
//
// Cycles: one command beat per clock once busy drops. Every cell of the row
// shifts or holds in parallel, so an insert or delete finishes in the cycle
// it is taken; its result beat shows on the next cycle, for one cycle.
// Reset: i_rst_n is synchronous, active low; it empties the list and drops
// busy for good in the cycle after release. The words themselves are not
// cleared: only entries below the count are ever read.
// Stalls: the receiver cannot stall, so the block never holds off a result.
`include "positional_list_engine_core_defines.svh"

module positional_list_engine_core #(
    parameter int DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_opcode,
    input  logic signed [31:0]          i_value,
    input  logic [7:0]                  i_position,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic signed [31:0]          o_read_value,
    output logic [4:0]                  o_entry_count
);

    // count width holds DEPTH itself; index width addresses the cells
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // width wide enough for both a position and count+1
    localparam int PW = ((CW > 8) ? CW : 8) + 1;
    localparam logic [CW-1:0] DEPTH_V = CW'(DEPTH);

    localparam int WW = ple_pkg::WORD_W;

    logic               r_busy;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_valid;
    logic [1:0]         r_status;
    logic [1:0]         n_status;
    logic [WW-1:0]      r_rd;
    logic [WW-1:0]      n_rd;
    logic [4:0]         r_cnt_out;

    logic               w_accept;
    logic               w_full;
    logic [PW-1:0]      w_pos;
    logic [PW-1:0]      w_len;
    logic [PW-1:0]      w_pos_m1;
    logic [IW-1:0]      w_idx;
    ple_pkg::t_cell_ctl w_ctl;

    logic [WW-1:0]      w_word [DEPTH];
    logic [WW-1:0]      w_rd   [DEPTH];
    logic [WW-1:0]      w_rd_or;

    assign w_accept = start && !busy;
    assign w_full   = (r_count == DEPTH_V);
    assign w_pos    = PW'(i_position);
    assign w_len    = PW'(r_count);
    assign w_pos_m1 = w_pos - PW'(1);

    // Decode the command into one broadcast control word for the row.
    always_comb begin
        w_ctl.op    = ple_pkg::CELL_HOLD;
        w_ctl.value = i_value;
        w_idx       = w_pos_m1[IW-1:0];
        n_status    = ple_pkg::ST_DONE;
        case (i_opcode)
            ple_pkg::OP_APPEND: begin
                if (w_full) begin
                    n_status = ple_pkg::ST_FULL;
                end else begin
                    w_ctl.op = ple_pkg::CELL_INS;
                    w_idx    = w_len[IW-1:0];
                end
            end
            ple_pkg::OP_INSERT: begin
                if (w_full) begin
                    n_status = ple_pkg::ST_FULL;
                end else if (i_position == 8'd0) begin
                    // position zero: just after the head
                    if (r_count == '0) begin
                        n_status = ple_pkg::ST_RANGE;
                    end else begin
                        w_ctl.op = ple_pkg::CELL_INS;
                        w_idx    = IW'(1);
                    end
                end else if (w_pos > w_len + PW'(1)) begin
                    n_status = ple_pkg::ST_RANGE;
                end else begin
                    w_ctl.op = ple_pkg::CELL_INS;
                end
            end
            ple_pkg::OP_DELETE: begin
                if (i_position == 8'd0 || w_pos > w_len) begin
                    n_status = ple_pkg::ST_RANGE;
                end else begin
                    w_ctl.op = ple_pkg::CELL_DEL;
                end
            end
            default: begin
                if (i_position == 8'd0 || w_pos > w_len) begin
                    n_status = ple_pkg::ST_RANGE;
                end else begin
                    w_ctl.op = ple_pkg::CELL_READ;
                end
            end
        endcase
        if (!w_accept) begin
            w_ctl.op = ple_pkg::CELL_HOLD;
        end
    end

    always_comb begin
        n_count = r_count;
        case (w_ctl.op)
            ple_pkg::CELL_INS: n_count = r_count + CW'(1);
            ple_pkg::CELL_DEL: n_count = r_count - CW'(1);
            default:           n_count = r_count;
        endcase
    end

    // Read data: each cell drives zero unless it is the one addressed.
    always_comb begin
        w_rd_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_or = w_rd_or | w_rd[k];
        end
    end
    assign n_rd = w_rd_or;

    // The cell row; ends see zero from the missing neighbor.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WW-1:0] w_left;
        logic [WW-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_word[g+1];
        end
        ple_cell #(
            .IDX (g),
            .IW  (IW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_idx   (w_idx),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_word[g]),
            .o_rd    (w_rd[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= 1'b0;
            r_count <= n_count;
            r_valid <= w_accept;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_rd      <= n_rd;
            r_cnt_out <= 5'(n_count);
        end
    end

    assign busy          = r_busy;
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_read_value  = r_rd;
    assign o_entry_count = r_cnt_out;

    `PLE_ASSERT_NOW(a_count_bound, 1'b1, r_count <= DEPTH_V)
    `PLE_ASSERT_NEXT(a_result_follows, w_accept, o_valid)
    `PLE_ASSERT_NOW(a_full_status, o_valid && o_status == ple_pkg::ST_FULL, w_full)
    `PLE_ASSERT_NOW(a_fail_zero, o_valid && o_status != ple_pkg::ST_DONE, o_read_value == 0)

endmodule

// ===== hdl/ple_cell.sv =====
// One storage cell of the list: holds a word, shifts from a neighbor.
// Depends on ple_pkg.
module ple_cell #(
    parameter int IDX = 0,
    parameter int IW  = 5
) (
    input  logic                         i_clk,
    input  ple_pkg::t_cell_ctl           i_ctl,
    input  logic [IW-1:0]                i_idx,
    input  logic [ple_pkg::WORD_W-1:0]   i_left,
    input  logic [ple_pkg::WORD_W-1:0]   i_right,
    output logic [ple_pkg::WORD_W-1:0]   o_word,
    output logic [ple_pkg::WORD_W-1:0]   o_rd
);

    localparam logic [IW-1:0] IDX_V = IW'(IDX);

    logic [ple_pkg::WORD_W-1:0] r_word;
    logic [ple_pkg::WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_ctl.op)
            ple_pkg::CELL_INS: begin
                // cells past the gap take the left neighbor
                if (IDX_V > i_idx) begin
                    n_word = i_left;
                end else if (IDX_V == i_idx) begin
                    n_word = i_ctl.value;
                end
            end
            ple_pkg::CELL_DEL: begin
                if (IDX_V >= i_idx) begin
                    n_word = i_right;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_rd   = (i_ctl.op == ple_pkg::CELL_READ && i_idx == IDX_V) ? r_word : '0;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for positional_list_engine_core: a directed table, then random commands.
// Depends on ple_pkg (opcode and status codes) and on the core RTL; nothing else.

module tb_top;

    localparam int LIST_DEPTH  = 16;
    localparam int RAND_BEATS  = 1700;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOWN_MAX   = 10;

    // One result beat, as the block presents it.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] rd_word;
        logic [4:0]         count;
    } t_list_result;

    // Row of the directed table; want is only used when pinned is set.
    typedef struct {
        logic [1:0]         op;
        logic signed [31:0] word;
        logic [7:0]         pos;
        bit                 pinned;
        t_list_result       want;
    } t_cmd_row;

    // Travels with each command beat, in issue order, so the acceptance side
    // knows whether a typed-in expectation replaces the predicted one.
    typedef struct {
        bit           pinned;
        t_list_result want;
    } t_beat_pin;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_opcode;
    logic signed [31:0] i_value;
    logic [7:0]         i_position;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_read_value;
    logic [4:0]         o_entry_count;

    // Predictor state: the list as the block should hold it.
    logic signed [31:0] list_mem [LIST_DEPTH];
    int unsigned        list_len;

    t_list_result       pending_results[$];
    t_beat_pin          pin_q[$];
    t_cmd_row           cmd_table[$];
    int unsigned        mismatches;
    int unsigned        cycles;
    int unsigned        beat_no;

    positional_list_engine_core #(
        .DEPTH(LIST_DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_entry_count(o_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one command to the predicted list and returns the result beat.
    // Full is checked ahead of the position for both kinds of add.
    function automatic t_list_result apply_list_op(logic [1:0] op, logic signed [31:0] word,
                                                   logic [7:0] pos);
        t_list_result res;
        int unsigned  slot;
        bit           do_put;
        int           k;
        res    = '{status: ple_pkg::ST_DONE, rd_word: '0, count: '0};
        do_put = 1'b0;
        slot   = 0;
        case (op)
            ple_pkg::OP_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = ple_pkg::ST_FULL;
                end else begin
                    do_put = 1'b1;
                    slot   = list_len;
                end
            end
            ple_pkg::OP_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = ple_pkg::ST_FULL;
                end else if (pos == 8'd0) begin
                    // position zero lands just behind the head
                    if (list_len == 0) begin
                        res.status = ple_pkg::ST_RANGE;
                    end else begin
                        do_put = 1'b1;
                        slot   = 1;
                    end
                end else if (pos > list_len + 1) begin
                    res.status = ple_pkg::ST_RANGE;
                end else begin
                    do_put = 1'b1;
                    slot   = pos - 1;
                end
            end
            ple_pkg::OP_DELETE: begin
                if (pos == 8'd0 || pos > list_len) begin
                    res.status = ple_pkg::ST_RANGE;
                end else begin
                    for (k = pos - 1; k + 1 < list_len; k++) begin
                        list_mem[k] = list_mem[k + 1];
                    end
                    list_len--;
                end
            end
            default: begin
                if (pos == 8'd0 || pos > list_len) begin
                    res.status = ple_pkg::ST_RANGE;
                end else begin
                    res.rd_word = list_mem[pos - 1];
                end
            end
        endcase
        if (do_put) begin
            for (k = list_len; k > slot; k--) begin
                list_mem[k] = list_mem[k - 1];
            end
            list_mem[slot] = word;
            list_len++;
        end
        res.count = list_len[4:0];
        return res;
    endfunction

    task automatic note_mismatch(string what, longint expv, longint gotv);
        mismatches++;
        if (mismatches <= SHOWN_MAX) begin
            $display("MISMATCH result %0d: %s expected %0h actual %0h",
                     beat_no, what, expv, gotv);
        end
    endtask

    // Acceptance and checking, both on the rising edge, reading pre-edge values.
    // A beat taken at this edge is queued first; its result cannot show before
    // the next edge, so the oldest entry is always the one being compared.
    always @(posedge i_clk) begin
        t_list_result pred;
        t_list_result want;
        t_beat_pin    pin;
        if (i_rst_n === 1'b1) begin
            if (start === 1'b1 && busy === 1'b0) begin
                pred = apply_list_op(i_opcode, i_value, i_position);
                if (pin_q.size() != 0) begin
                    pin = pin_q.pop_front();
                    if (pin.pinned) begin
                        pred = pin.want;
                    end
                end
                pending_results.push_back(pred);
            end
            if (o_valid === 1'b1) begin
                if (pending_results.size() == 0) begin
                    note_mismatch("unexpected beat, count", 0, o_entry_count);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        note_mismatch("status", want.status, o_status);
                    if (o_read_value !== want.rd_word)
                        note_mismatch("read_value", want.rd_word, o_read_value);
                    if (o_entry_count !== want.count)
                        note_mismatch("entry_count", want.count, o_entry_count);
                end
                beat_no++;
            end
        end
    end

    // Watchdog; generous against the slowest legal run (every beat after a
    // long gap, plus reset and drains).
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("positional_list_engine_core regression: fail");
            $finish;
        end
    end

    task automatic add_row(logic [1:0] op, logic signed [31:0] word, logic [7:0] pos,
                           bit pinned, logic [1:0] st, logic signed [31:0] rd, logic [4:0] cnt);
        t_cmd_row row;
        row.op     = op;
        row.word   = word;
        row.pos    = pos;
        row.pinned = pinned;
        row.want   = '{status: st, rd_word: rd, count: cnt};
        cmd_table.push_back(row);
    endtask

    // Presents one command beat and holds it until the block takes it.
    task automatic send_cmd(logic [1:0] op, logic signed [31:0] word, logic [7:0] pos,
                            bit pinned, t_list_result want);
        t_beat_pin pin;
        pin.pinned = pinned;
        pin.want   = want;
        pin_q.push_back(pin);
        start      <= 1'b1;
        i_opcode   <= op;
        i_value    <= word;
        i_position <= pos;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Random idle cycles on the command side; pct is the chance per cycle.
    task automatic sender_gap(int unsigned pct);
        while ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Hold off until every outstanding result has come back. The queue is
    // looked at on the falling edge, clear of the rising-edge bookkeeping.
    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
        @(posedge i_clk);
    endtask

    // Random command mix. In grow stretches adds dominate, in shrink
    // stretches deletes do, so the list swings between empty and full.
    task automatic run_random(int unsigned beats, int unsigned gap_pct);
        bit                 growing;
        int unsigned        stretch;
        int unsigned        pick;
        int unsigned        n;
        logic [1:0]         op;
        logic signed [31:0] word;
        logic [7:0]         pos;
        t_list_result       none;
        growing = 1'b1;
        stretch = $urandom_range(20, 60);
        none    = '0;
        for (n = 0; n < beats; n++) begin
            if (stretch == 0) begin
                growing = !growing;
                stretch = $urandom_range(20, 60);
            end
            stretch--;
            pick = $urandom_range(0, 99);
            if (growing)
                op = (pick < 30) ? ple_pkg::OP_APPEND : (pick < 65) ? ple_pkg::OP_INSERT :
                     (pick < 80) ? ple_pkg::OP_DELETE : ple_pkg::OP_READ;
            else
                op = (pick < 10) ? ple_pkg::OP_APPEND : (pick < 25) ? ple_pkg::OP_INSERT :
                     (pick < 75) ? ple_pkg::OP_DELETE : ple_pkg::OP_READ;
            case ($urandom_range(0, 19))
                0:       word = 32'sh7FFF_FFFF;
                1:       word = 32'sh8000_0000;
                2:       word = '0;
                3:       word = -32'sd1;
                default: word = $urandom;
            endcase
            // mostly positions near the live range, now and then anything
            if ($urandom_range(0, 99) < 85)
                pos = 8'($urandom_range(0, LIST_DEPTH + 1));
            else
                pos = 8'($urandom_range(0, 255));
            send_cmd(op, word, pos, 1'b0, none);
            sender_gap(gap_pct);
        end
    endtask

    initial begin
        int r;
        mismatches  = 0;
        cycles      = 0;
        beat_no     = 0;
        list_len    = 0;
        for (r = 0; r < LIST_DEPTH; r++) begin
            list_mem[r] = '0;
        end

        // Directed table. Typed-in results on the easy rows; the rest go
        // through the predictor.
        // read on empty, delete at zero, after head on empty, past count+1
        add_row(ple_pkg::OP_READ, '0, 8'd1, 1, ple_pkg::ST_RANGE, '0, 5'd0);
        add_row(ple_pkg::OP_DELETE, '0, 8'd0, 1, ple_pkg::ST_RANGE, '0, 5'd0);
        add_row(ple_pkg::OP_INSERT, 32'sd5, 8'd0, 1, ple_pkg::ST_RANGE, '0, 5'd0);
        add_row(ple_pkg::OP_INSERT, 32'sd6, 8'd2, 1, ple_pkg::ST_RANGE, '0, 5'd0);
        // head insert, append, then one behind the head
        add_row(ple_pkg::OP_INSERT, 32'sh7FFF_FFFF, 8'd1, 1, ple_pkg::ST_DONE, '0, 5'd1);
        add_row(ple_pkg::OP_APPEND, 32'sh8000_0000, 8'd255, 1, ple_pkg::ST_DONE, '0, 5'd2);
        add_row(ple_pkg::OP_INSERT, -32'sd1, 8'd0, 1, ple_pkg::ST_DONE, '0, 5'd3);
        add_row(ple_pkg::OP_READ, '0, 8'd2, 1, ple_pkg::ST_DONE, -32'sd1, 5'd3);
        // insert at count+1, then beyond it
        add_row(ple_pkg::OP_INSERT, 32'sh1234_5678, 8'd4, 1, ple_pkg::ST_DONE, '0, 5'd4);
        add_row(ple_pkg::OP_INSERT, 32'sd7, 8'd6, 1, ple_pkg::ST_RANGE, '0, 5'd4);
        add_row(ple_pkg::OP_READ, '0, 8'd0, 1, ple_pkg::ST_RANGE, '0, 5'd4);
        add_row(ple_pkg::OP_DELETE, '0, 8'd255, 1, ple_pkg::ST_RANGE, '0, 5'd4);
        add_row(ple_pkg::OP_DELETE, '0, 8'd1, 1, ple_pkg::ST_DONE, '0, 5'd3);
        add_row(ple_pkg::OP_READ, '0, 8'd1, 1, ple_pkg::ST_DONE, -32'sd1, 5'd3);
        for (r = 0; r < LIST_DEPTH - 3; r++) begin
            // fill to the brim
            add_row(ple_pkg::OP_APPEND, $urandom, 8'd0, 0, ple_pkg::ST_DONE, '0, '0);
        end
        add_row(ple_pkg::OP_APPEND, 32'sd1, 8'd0, 1, ple_pkg::ST_FULL, '0, 5'd16);
        add_row(ple_pkg::OP_INSERT, 32'sd2, 8'd1, 1, ple_pkg::ST_FULL, '0, 5'd16);
        add_row(ple_pkg::OP_READ, '0, 8'd16, 0, ple_pkg::ST_DONE, '0, '0);
        add_row(ple_pkg::OP_READ, '0, 8'd17, 1, ple_pkg::ST_RANGE, '0, 5'd16);
        add_row(ple_pkg::OP_DELETE, '0, 8'd16, 1, ple_pkg::ST_DONE, '0, 5'd15);

        // All inputs known from time zero, with reset held low before release.
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_opcode   <= ple_pkg::OP_APPEND;
        i_value    <= '0;
        i_position <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (cmd_table[r]) begin
            send_cmd(cmd_table[r].op, cmd_table[r].word, cmd_table[r].pos,
                     cmd_table[r].pinned, cmd_table[r].want);
            sender_gap(14);
        end

        // Three random phases: light gaps, heavy gaps, back to back. The
        // sender stops between them until the result side has gone quiet.
        drain_results();
        run_random(RAND_BEATS / 3, 14);
        drain_results();
        run_random(RAND_BEATS / 3, 64);
        drain_results();
        run_random(RAND_BEATS - 2 * (RAND_BEATS / 3), 0);

        drain_results();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("positional_list_engine_core regression: pass");
        end else begin
            $display("positional_list_engine_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/positional_list_engine_core.sv
tb/tb_top.sv
